@@ hdl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Operation codes, status codes and the control word sent along the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef logic [DATA_W-1:0] t_data;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ hdl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor's entry; on remove it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
    parameter int PRIO_BITS = 8
) (
    input  wire                      i_clk,
    input  wire spq_pkg::t_cell_ctrl i_ctrl,
    input  wire                      i_occupied,
    input  wire spq_pkg::t_data      i_new_value,
    input  wire [PRIO_BITS-1:0]      i_new_prio,
    input  wire                      i_left_moves,
    input  wire spq_pkg::t_data      i_left_value,
    input  wire [PRIO_BITS-1:0]      i_left_prio,
    input  wire spq_pkg::t_data      i_right_value,
    input  wire [PRIO_BITS-1:0]      i_right_prio,
    output logic                     o_moves,
    output spq_pkg::t_data           o_value,
    output logic [PRIO_BITS-1:0]     o_prio
);

    spq_pkg::t_data       r_value;
    logic [PRIO_BITS-1:0] r_prio;
    spq_pkg::t_data       n_value;
    logic [PRIO_BITS-1:0] n_prio;

    // new entry belongs at or before this slot
    assign o_moves = !i_occupied || (r_prio > i_new_prio);

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctrl.ins) begin
            if (i_left_moves) begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end else if (o_moves) begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end
        end else if (i_ctrl.rem) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

`default_nettype wire

@@ hdl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue kept sorted in a row of cells
// Entries are held in service order; lowest priority number leaves first,
// equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries an op with a data word and a
//   priority: insert (op 0) or remove head (op 1). Every input transaction
//   yields exactly one output transaction (o_valid/i_ready) carrying the
//   removed data word with its valid flag, a status code, the empty flag and
//   the entry count after the step.
//   Insert on a full queue is dropped with status 2; remove on an empty
//   queue returns status 1 and out_valid 0.
//   The result is registered: all cells compare against the new priority in
//   parallel and shift by one slot at the edge that takes the input, so one
//   transaction is taken every cycle while the receiver keeps up. The single
//   output register sets the rate: a new input is taken while the held
//   result is being taken or when none is held. If the receiver stalls, the
//   result is held and o_ready drops until it leaves.
//   Reset clears the entry count and the output valid flag; slot contents
//   are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire                           i_op,
    input  wire signed [31:0]             i_item_value,
    input  wire [PRIO_BITS-1:0]           i_item_priority,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic signed [31:0]            o_out_value,
    output logic                          o_out_valid,
    output logic [spq_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_now_empty,
    output logic [CNT_W-1:0]              o_entry_count
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         accept;
    logic                         is_full;
    logic                         is_empty;
    spq_pkg::t_cell_ctrl          ctrl;
    logic [spq_pkg::STATUS_W-1:0] n_status;

    logic                 moves [DEPTH];
    spq_pkg::t_data       cell_value [DEPTH];
    logic [PRIO_BITS-1:0] cell_prio [DEPTH];

    logic                         r_valid;
    spq_pkg::t_data               r_out_value;
    logic                         r_out_valid;
    logic [spq_pkg::STATUS_W-1:0] r_status;
    logic                         r_now_empty;
    logic [CNT_W-1:0]             r_entry_count;

    assign o_ready  = !r_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    always_comb begin
        ctrl     = '0;
        n_count  = r_count;
        n_status = spq_pkg::STAT_OK;
        if (accept) begin
            if (i_op == spq_pkg::OP_INSERT) begin
                if (is_full) begin
                    n_status = spq_pkg::STAT_FULL;
                end else begin
                    ctrl.ins = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end else begin
                if (is_empty) begin
                    n_status = spq_pkg::STAT_EMPTY;
                end else begin
                    ctrl.rem = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 left_moves;
        spq_pkg::t_data       left_value;
        logic [PRIO_BITS-1:0] left_prio;
        spq_pkg::t_data       right_value;
        logic [PRIO_BITS-1:0] right_prio;

        if (g == 0) begin : g_first
            assign left_moves = 1'b0;
            assign left_value = cell_value[g];
            assign left_prio  = cell_prio[g];
        end else begin : g_inner
            assign left_moves = moves[g-1];
            assign left_value = cell_value[g-1];
            assign left_prio  = cell_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_value = cell_value[g];
            assign right_prio  = cell_prio[g];
        end else begin : g_mid
            assign right_value = cell_value[g+1];
            assign right_prio  = cell_prio[g+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (r_count > CNT_W'(g)),
            .i_new_value   (spq_pkg::t_data'(i_item_value)),
            .i_new_prio    (i_item_priority),
            .i_left_moves  (left_moves),
            .i_left_value  (left_value),
            .i_left_prio   (left_prio),
            .i_right_value (right_value),
            .i_right_prio  (right_prio),
            .o_moves       (moves[g]),
            .o_value       (cell_value[g]),
            .o_prio        (cell_prio[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value   <= ctrl.rem ? cell_value[0] : '0;
            r_out_valid   <= ctrl.rem;
            r_status      <= n_status;
            r_now_empty   <= (n_count == '0);
            r_entry_count <= n_count;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_value   = signed'(r_out_value);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_now_empty   = r_now_empty;
    assign o_entry_count = r_entry_count;

endmodule

`default_nettype wire

@@ hdl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_port_checker: port-level checks for the sorted priority queue
// Watches the result channel for consistent status, flags, data and count.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_port_checker #(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_valid,
    input wire                          i_ready,
    input wire signed [31:0]            o_out_value,
    input wire                          o_out_valid,
    input wire [spq_pkg::STATUS_W-1:0]  o_status,
    input wire                          o_now_empty,
    input wire [CNT_W-1:0]              o_entry_count
);

    // held result stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_entry_count) && $stable(o_status))
        else $error("result dropped or changed while stalled");

    // a removed entry only comes with an ok status
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> o_status == spq_pkg::STAT_OK)
        else $error("removed entry with error status");

    // no removed entry means a zero data word
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> o_out_value == '0)
        else $error("data word without a removed entry");

    // full drop reports a full queue, empty remove an empty one
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != spq_pkg::STAT_FULL || o_entry_count == CNT_W'(DEPTH))
                 && (o_status != spq_pkg::STAT_EMPTY || o_entry_count == '0))
        else $error("error status disagrees with entry count");

    // empty flag matches count, count in range
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_now_empty == (o_entry_count == '0))
                 && (o_entry_count <= CNT_W'(DEPTH)))
        else $error("empty flag or entry count wrong");

endmodule

bind sorted_priority_queue spq_port_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_value   (o_out_value),
    .o_out_valid   (o_out_valid),
    .o_status      (o_status),
    .o_now_empty   (o_now_empty),
    .o_entry_count (o_entry_count)
);

`default_nettype wire
